@@ design/lps_pkg.sv @@
// Shared constants and types for the lexicographic permutation stepper.
package lps_pkg;

	// Default of the element count parameter.
	localparam int MAX_ELEMS_DEF = 10;

	// Result layout: ten 4-bit slots, position 0 in the low bits.
	localparam int SLOT_W     = 4;
	localparam int OUT_SLOTS  = 10;
	localparam int PERM_W     = SLOT_W * OUT_SLOTS;
	localparam int OUT_DATA_W = ((PERM_W + 7) / 8) * 8;
	localparam int IN_DATA_W  = 8;

	// Configuration port.
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;
	localparam int REG_IDX_W    = APB_ADDR_W - 2;
	localparam int ELEM_COUNT_W = 4;
	localparam logic [ELEM_COUNT_W-1:0] ELEM_COUNT_RST = 4'd10;

	// Register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_ELEMENT_COUNT = 1'b0,
		REG_UNUSED        = 1'b1
	} reg_idx_t;

endpackage

@@ design/lps_cfg.sv @@
// Configuration registers: APB access and the clamped active element count.
module lps_cfg
	import lps_pkg::*;
#(
	parameter int MAX_ELEMS = MAX_ELEMS_DEF,
	parameter int CNT_W     = $clog2(MAX_ELEMS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [CNT_W-1:0]      active_count
);

	logic [ELEM_COUNT_W-1:0] element_count_q;
	reg_idx_t                reg_idx;
	logic                    wr_en;

	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= ELEM_COUNT_RST;
		end else if (wr_en && (reg_idx == REG_ELEMENT_COUNT)) begin
			element_count_q <= pwdata[ELEM_COUNT_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ELEMENT_COUNT: prdata = APB_DATA_W'(element_count_q);
			default:           prdata = '0;
		endcase
	end

	// Zero counts as one element; counts above the storage saturate.
	always_comb begin
		if (element_count_q == '0) begin
			active_count = CNT_W'(1);
		end else if (int'(element_count_q) > MAX_ELEMS) begin
			active_count = CNT_W'(MAX_ELEMS);
		end else begin
			active_count = CNT_W'(element_count_q);
		end
	end

endmodule

@@ design/lps_step.sv @@
// Combinational successor logic: pivot search, swap, suffix reversal, packing.
module lps_step
	import lps_pkg::*;
#(
	parameter int MAX_ELEMS = MAX_ELEMS_DEF,
	parameter int ELEM_W    = $clog2(MAX_ELEMS + 1),
	parameter int CNT_W     = $clog2(MAX_ELEMS + 1),
	parameter int IDX_W     = $clog2(MAX_ELEMS)
) (
	input  logic [MAX_ELEMS-1:0][ELEM_W-1:0] order,
	input  logic                             restart,
	input  logic [CNT_W-1:0]                 n,
	output logic [MAX_ELEMS-1:0][ELEM_W-1:0] order_next,
	output logic [PERM_W-1:0]                permutation,
	output logic                             is_final
);

	localparam int SUM_W = CNT_W + 1;

	logic [MAX_ELEMS-1:0][ELEM_W-1:0] ident;
	logic [MAX_ELEMS-1:0][ELEM_W-1:0] cur;
	logic [MAX_ELEMS-1:0]             asc;
	logic [MAX_ELEMS-1:0]             gt;
	logic [IDX_W-1:0]                 pivot;
	logic [IDX_W-1:0]                 succ;
	logic                             found;
	logic [ELEM_W-1:0]                pivot_val;
	logic [SUM_W-1:0]                 rev_sum;

	always_comb begin
		for (int k = 0; k < MAX_ELEMS; k++) begin
			ident[k] = ELEM_W'(k + 1);
		end
	end

	assign cur = restart ? ident : order;

	// Ascent flags between neighbors inside the active window.
	always_comb begin
		asc = '0;
		for (int k = 0; k < MAX_ELEMS - 1; k++) begin
			asc[k] = (SUM_W'(k + 1) < SUM_W'(n)) && (cur[k] < cur[k+1]);
		end
	end

	// Rightmost ascent is the pivot.
	always_comb begin
		pivot = '0;
		found = 1'b0;
		for (int k = 0; k < MAX_ELEMS - 1; k++) begin
			if (asc[k]) begin
				pivot = IDX_W'(k);
				found = 1'b1;
			end
		end
	end

	assign pivot_val = cur[pivot];
	assign is_final  = !found;

	// Rightmost element after the pivot that is larger than it.
	always_comb begin
		gt   = '0;
		succ = '0;
		for (int k = 0; k < MAX_ELEMS; k++) begin
			gt[k] = (IDX_W'(k) > pivot) && (SUM_W'(k) < SUM_W'(n)) && (cur[k] > pivot_val);
		end
		for (int k = 0; k < MAX_ELEMS; k++) begin
			if (gt[k]) begin
				succ = IDX_W'(k);
			end
		end
	end

	// Position k of the reversed suffix reads from position pivot + n - k.
	assign rev_sum = SUM_W'(pivot) + SUM_W'(n);

	always_comb begin
		logic [SUM_W-1:0] src;
		for (int k = 0; k < MAX_ELEMS; k++) begin
			src = rev_sum - SUM_W'(k);
			if (!found) begin
				order_next[k] = ident[k];
			end else if (IDX_W'(k) == pivot) begin
				order_next[k] = cur[succ];
			end else if ((IDX_W'(k) > pivot) && (SUM_W'(k) < SUM_W'(n))) begin
				if (src[IDX_W-1:0] == succ) begin
					order_next[k] = pivot_val;
				end else begin
					order_next[k] = cur[src[IDX_W-1:0]];
				end
			end else begin
				order_next[k] = cur[k];
			end
		end
	end

	// Pack the active positions; wider values keep their low four bits.
	always_comb begin
		permutation = '0;
		for (int p = 0; p < OUT_SLOTS; p++) begin
			if ((p < MAX_ELEMS) && (SUM_W'(p) < SUM_W'(n))) begin
				permutation[p*SLOT_W +: SLOT_W] = SLOT_W'(cur[p]);
			end
		end
	end

endmodule

@@ design/lexicographic_permutation_stepper.sv @@
// Top level of the lexicographic permutation stepper.
// A result reaches the master side in the cycle after its item is accepted.
// One item per cycle unless stalled; the stored ordering steps in the same cycle.
// The output register stays full while the consumer stalls, and a new item is taken
// whenever that register is empty or being emptied. Reset loads the identity
// ordering, sets the element count to ten and empties the output register.
module lexicographic_permutation_stepper
	import lps_pkg::*;
#(
	parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Slave side: bit 0 restart, bits 7:1 zero.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// Master side: bits 39:0 permutation; tlast carries is_final.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int ELEM_W = $clog2(MAX_ELEMS + 1);
	localparam int CNT_W  = $clog2(MAX_ELEMS + 1);
	localparam int IDX_W  = $clog2(MAX_ELEMS);

	logic [CNT_W-1:0]                 active_count;
	logic [MAX_ELEMS-1:0][ELEM_W-1:0] order_q;
	logic [MAX_ELEMS-1:0][ELEM_W-1:0] order_next;
	logic [PERM_W-1:0]                perm_next;
	logic                             final_next;
	logic [PERM_W-1:0]                perm_q;
	logic                             final_q;
	logic                             out_valid_q;
	logic                             in_fire;

	lps_cfg #(
		.MAX_ELEMS (MAX_ELEMS),
		.CNT_W     (CNT_W)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.active_count (active_count)
	);

	// The whole successor step is one pass of comparators and muxes over the
	// stored ordering, so the stored state is ready for the next item at once.
	lps_step #(
		.MAX_ELEMS (MAX_ELEMS),
		.ELEM_W    (ELEM_W),
		.CNT_W     (CNT_W),
		.IDX_W     (IDX_W)
	) u_step (
		.order       (order_q),
		.restart     (s_axis_tdata[0]),
		.n           (active_count),
		.order_next  (order_next),
		.permutation (perm_next),
		.is_final    (final_next)
	);

	// Accept whenever the output register is free or drains this cycle.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_ELEMS; k++) begin
				order_q[k] <= ELEM_W'(k + 1);
			end
		end else if (in_fire) begin
			order_q <= order_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload needs no reset; it is qualified by out_valid_q.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			perm_q  <= perm_next;
			final_q <= final_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(perm_q);
	assign m_axis_tlast  = final_q;

endmodule
